@@ design/spc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the spindle PWM controller
// Register indexes, command codes, sequencer states and the control and
// status words between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_RPM_MIN      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RPM_MAX      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_SLOPE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PWM_MIN_DUTY = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PWM_MAX_DUTY = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LASER_MODE   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_AT_ZERO  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT_EN    = 3'd7;

  localparam logic [1:0] CMD_OFF = 2'd0;
  localparam logic [1:0] CMD_CW  = 2'd1;

  localparam logic [1:0] STATUS_OFF = 2'd0;
  localparam logic [1:0] STATUS_CW  = 2'd1;
  localparam logic [1:0] STATUS_CCW = 2'd2;

  localparam int OVR_W   = 8;
  localparam int FRAC_W  = 16;
  localparam int PERCENT = 100;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_FIX  = 6'b001000,
    S_GRAD = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic fix;
    logic grad;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

@@ design/spindle_pwm_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spindle_pwm_controller: linear rpm-to-PWM spindle control
// Takes one spindle command word at a time and returns one status word with
// duty, pins, actual speed and spindle status.
// ----------------------------------------------------------------------------
// An accepted command word passes load, rpm times override, the divide by 100
// (reciprocal multiply and one correction step), the gradient multiply and
// commit. Disable, abort and check-mode words skip from load to commit.
// The sequencer carries one word at a time; a new word is taken while the
// previous status word waits in the output register. Configuration registers
// are written through cfg_we/cfg_addr/cfg_wdata; the user must write them only
// while the block is idle; the block itself does not enforce this.
module spindle_pwm_controller #(
  parameter int PWM_BITS = 10,
  parameter int RPM_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_command,
  input  wire logic [RPM_BITS-1:0]           in_requested_rpm,
  input  wire logic [7:0]                    in_override_percent,
  input  wire logic                          in_abort_active,
  input  wire logic                          in_check_mode,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [PWM_BITS-1:0]                out_pwm_duty,
  output logic                               out_pwm_running,
  output logic                               out_spindle_enable_pin,
  output logic                               out_laser_en_pin,
  output logic                               out_direction_pin,
  output logic [RPM_BITS-1:0]                out_actual_speed,
  output logic [1:0]                         out_spindle_status,
  output logic                               out_accepted,
  output logic                               out_report_now,
  input  wire logic                          cfg_we,
  input  wire logic [spc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [PWM_BITS+15:0]          cfg_wdata
);
  import spc_pkg::*;

  logic [RPM_BITS-1:0] rpm_min_r, rpm_max_r;
  logic [PWM_BITS+15:0] grad_r;
  logic [PWM_BITS-1:0] min_duty_r, max_duty_r;
  logic                laser_r, oz_r, inv_r;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_min_r  <= '0;
      rpm_max_r  <= RPM_BITS'(1000);
      grad_r     <= (PWM_BITS+16)'(16711);
      min_duty_r <= PWM_BITS'(1);
      max_duty_r <= PWM_BITS'(255);
      laser_r    <= 1'b0;
      oz_r       <= 1'b0;
      inv_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RPM_MIN:      rpm_min_r  <= cfg_wdata[RPM_BITS-1:0];
        REG_RPM_MAX:      rpm_max_r  <= cfg_wdata[RPM_BITS-1:0];
        REG_DUTY_SLOPE:   grad_r     <= cfg_wdata;
        REG_PWM_MIN_DUTY: min_duty_r <= cfg_wdata[PWM_BITS-1:0];
        REG_PWM_MAX_DUTY: max_duty_r <= cfg_wdata[PWM_BITS-1:0];
        REG_LASER_MODE:   laser_r    <= cfg_wdata[0];
        REG_OFF_AT_ZERO:  oz_r       <= cfg_wdata[0];
        REG_INVERT_EN:    inv_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  spc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  spc_dp #(
    .PWM_BITS (PWM_BITS),
    .RPM_BITS (RPM_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_command             (in_command),
    .in_requested_rpm       (in_requested_rpm),
    .in_override_percent    (in_override_percent),
    .in_abort_active        (in_abort_active),
    .in_check_mode          (in_check_mode),
    .rpm_min                (rpm_min_r),
    .rpm_max                (rpm_max_r),
    .duty_slope             (grad_r),
    .pwm_min_duty           (min_duty_r),
    .pwm_max_duty           (max_duty_r),
    .laser_mode             (laser_r),
    .off_at_zero_speed      (oz_r),
    .invert_enables         (inv_r),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_pwm_duty           (out_pwm_duty),
    .out_pwm_running        (out_pwm_running),
    .out_spindle_enable_pin (out_spindle_enable_pin),
    .out_laser_en_pin       (out_laser_en_pin),
    .out_direction_pin      (out_direction_pin),
    .out_actual_speed       (out_actual_speed),
    .out_spindle_status     (out_spindle_status),
    .out_accepted           (out_accepted),
    .out_report_now         (out_report_now)
  );

endmodule
`default_nettype wire

@@ design/spc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spc_ctrl: sequencer of the spindle PWM controller
// Steps one command word through scaling, division, gradient and commit.
// ----------------------------------------------------------------------------
module spc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output spc_pkg::ctrl_cmd_t     cmd,
  input  wire spc_pkg::ctrl_sts_t sts
);
  import spc_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.skip ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_GRAD;
      end
      S_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free) else $error("commit while output word held");
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE) else $error("no return to idle");
  a_load_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !sts.skip) |=> state_r == S_MUL) else $error("mapping skipped");

endmodule
`default_nettype wire

@@ design/spc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spc_dp: datapath of the spindle PWM controller
// Override scaling, divide by 100, linear duty map, spindle state and the
// output word register.
// ----------------------------------------------------------------------------
module spc_dp #(
  parameter int PWM_BITS = 10,
  parameter int RPM_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire spc_pkg::ctrl_cmd_t      cmd,
  output spc_pkg::ctrl_sts_t           sts,
  input  wire logic [1:0]              in_command,
  input  wire logic [RPM_BITS-1:0]     in_requested_rpm,
  input  wire logic [7:0]              in_override_percent,
  input  wire logic                    in_abort_active,
  input  wire logic                    in_check_mode,
  input  wire logic [RPM_BITS-1:0]     rpm_min,
  input  wire logic [RPM_BITS-1:0]     rpm_max,
  input  wire logic [PWM_BITS+15:0]    duty_slope,
  input  wire logic [PWM_BITS-1:0]     pwm_min_duty,
  input  wire logic [PWM_BITS-1:0]     pwm_max_duty,
  input  wire logic                    laser_mode,
  input  wire logic                    off_at_zero_speed,
  input  wire logic                    invert_enables,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [PWM_BITS-1:0]          out_pwm_duty,
  output logic                         out_pwm_running,
  output logic                         out_spindle_enable_pin,
  output logic                         out_laser_en_pin,
  output logic                         out_direction_pin,
  output logic [RPM_BITS-1:0]          out_actual_speed,
  output logic [1:0]                   out_spindle_status,
  output logic                         out_accepted,
  output logic                         out_report_now
);
  import spc_pkg::*;

  localparam int P     = RPM_BITS + OVR_W;
  localparam int SH    = P + 7;
  localparam int SW    = P - 6;
  localparam int GW    = PWM_BITS + FRAC_W;
  localparam int LW    = RPM_BITS + PWM_BITS;
  localparam logic [P:0] RECIP = (P+1)'((64'd1 << SH) / 64'd100);

  logic [1:0]          cmd_r;
  logic [RPM_BITS-1:0] rpm_r;
  logic [OVR_W-1:0]    ovr_r;
  logic                ign_r;
  logic [P-1:0]        prod_r;
  logic [SW-1:0]       est_r;
  logic [SW-1:0]       s_r;
  logic                hi_r, lo_r, zero_r;
  logic [LW-1:0]       lin_r;

  logic [2*P:0]           wide;
  logic [P:0]             prod_ext, est_ext, est_x100, rem;
  logic [RPM_BITS-1:0]    diff;
  logic [RPM_BITS+GW-1:0] prod2;
  logic [LW:0]            lin_sum;
  logic [PWM_BITS-1:0]    duty_lin, map_duty;
  logic [RPM_BITS-1:0]    map_speed;
  logic                   in_ccw;

  logic [PWM_BITS-1:0] duty_r, duty_nxt;
  logic                run_r, run_nxt, sen_r, sen_nxt, len_r, len_nxt, dir_r, dir_nxt;
  logic [RPM_BITS-1:0] speed_r, speed_nxt;
  logic                out_valid_r;
  logic [1:0]          status_nxt;

  assign sts.skip     = in_abort_active || in_check_mode || (in_command == CMD_OFF);
  assign sts.out_free = !out_valid_r || out_ready;
  assign in_ccw       = (in_command != CMD_CW);

  assign wide     = (2*P+1)'(prod_r) * (2*P+1)'(RECIP);
  assign prod_ext = (P+1)'(prod_r);
  assign est_ext  = (P+1)'(est_r);
  assign est_x100 = est_ext * (P+1)'(PERCENT);
  assign rem      = prod_ext - est_x100;

  assign diff  = s_r[RPM_BITS-1:0] - rpm_min;
  assign prod2 = (RPM_BITS+GW)'(diff) * (RPM_BITS+GW)'(duty_slope);

  // hold the command word, then step the mapping one stage per strobe
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      rpm_r <= (laser_mode && in_ccw) ? '0 : in_requested_rpm;
      ovr_r <= in_override_percent;
      ign_r <= in_abort_active || in_check_mode;
    end
    if (cmd.mul) begin
      prod_r <= P'(rpm_r) * P'(ovr_r);
    end
    if (cmd.div) begin
      est_r <= wide[2*P:SH];
    end
    if (cmd.fix) begin
      s_r <= (rem >= (P+1)'(PERCENT)) ? est_r + SW'(1) : est_r;
    end
    if (cmd.grad) begin
      hi_r   <= (rpm_min >= rpm_max) || (s_r >= SW'(rpm_max));
      lo_r   <= (s_r <= SW'(rpm_min));
      zero_r <= (s_r == '0);
      lin_r  <= prod2[RPM_BITS+GW-1:FRAC_W];
    end
  end

  assign lin_sum  = (LW+1)'(lin_r) + (LW+1)'(pwm_min_duty);
  assign duty_lin = (lin_sum > (LW+1)'(pwm_max_duty)) ? pwm_max_duty
                                                      : lin_sum[PWM_BITS-1:0];

  always_comb begin
    if (hi_r) begin
      map_duty  = pwm_max_duty;
      map_speed = rpm_max;
    end else if (lo_r && zero_r) begin
      map_duty  = '0;
      map_speed = '0;
    end else if (lo_r) begin
      map_duty  = pwm_min_duty;
      map_speed = rpm_min;
    end else begin
      map_duty  = duty_lin;
      map_speed = s_r[RPM_BITS-1:0];
    end
  end

  always_comb begin
    duty_nxt  = duty_r;
    run_nxt   = run_r;
    sen_nxt   = sen_r;
    len_nxt   = len_r;
    dir_nxt   = dir_r;
    speed_nxt = speed_r;
    if (!ign_r) begin
      if (cmd_r == CMD_OFF) begin
        speed_nxt = '0;
        run_nxt   = 1'b0;
        sen_nxt   = 1'b0;
        len_nxt   = 1'b0;
      end else begin
        if (laser_mode) begin
          len_nxt = 1'b1;
        end else begin
          dir_nxt = (cmd_r != CMD_CW);
          sen_nxt = 1'b1;
        end
        duty_nxt  = map_duty;
        speed_nxt = map_speed;
        run_nxt   = (map_duty != '0);
        if (off_at_zero_speed) begin
          if (map_duty == '0) begin
            sen_nxt = 1'b0;
            len_nxt = 1'b0;
          end else begin
            sen_nxt = 1'b1;
          end
        end
      end
    end
    if (sen_nxt || len_nxt) begin
      status_nxt = dir_nxt ? STATUS_CCW : STATUS_CW;
    end else begin
      status_nxt = STATUS_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r      <= '0;
      run_r       <= 1'b0;
      sen_r       <= 1'b0;
      len_r       <= 1'b0;
      dir_r       <= 1'b0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        duty_r      <= duty_nxt;
        run_r       <= run_nxt;
        sen_r       <= sen_nxt;
        len_r       <= len_nxt;
        dir_r       <= dir_nxt;
        speed_r     <= speed_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_pwm_duty           <= duty_nxt;
      out_pwm_running        <= run_nxt;
      out_spindle_enable_pin <= sen_nxt ^ invert_enables;
      out_laser_en_pin       <= len_nxt ^ invert_enables;
      out_direction_pin      <= dir_nxt;
      out_actual_speed       <= speed_nxt;
      out_spindle_status     <= status_nxt;
      out_accepted           <= !ign_r;
      out_report_now         <= !ign_r;
    end
  end

  assign out_valid = out_valid_r;

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r) else $error("output word dropped");
  a_run_duty: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (duty_r != '0)) else $error("running with zero duty");
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.fix) |-> (rem < (P+1)'(2*PERCENT))) else $error("quotient estimate off");

endmodule
`default_nettype wire

@@ tb/sv/spindle_status_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spindle_status_checker: status word predictor and comparator
// Watches the command, status and register ports of the spindle PWM
// controller. It tracks the register values and the spindle state, predicts
// one status word per accepted command word, and compares each status word
// taken from the block against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module spindle_status_checker #(
  parameter int PWM_BITS = 10,
  parameter int RPM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              in_command,
  input  logic [RPM_BITS-1:0]     in_requested_rpm,
  input  logic [7:0]              in_override_percent,
  input  logic                    in_abort_active,
  input  logic                    in_check_mode,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [PWM_BITS-1:0]     out_pwm_duty,
  input  logic                    out_pwm_running,
  input  logic                    out_spindle_enable_pin,
  input  logic                    out_laser_en_pin,
  input  logic                    out_direction_pin,
  input  logic [RPM_BITS-1:0]     out_actual_speed,
  input  logic [1:0]              out_spindle_status,
  input  logic                    out_accepted,
  input  logic                    out_report_now,
  input  logic                    cfg_we,
  input  logic [spc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [PWM_BITS+15:0]    cfg_wdata,
  output int unsigned             error_count,
  output int unsigned             outstanding
);
  import spc_pkg::*;

  localparam logic [PWM_BITS-1:0] DUTY_OFF = '0;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic [PWM_BITS-1:0] pwm_duty;
    logic                pwm_running;
    logic                spindle_pin;
    logic                laser_pin;
    logic                direction;
    logic [RPM_BITS-1:0] speed;
    logic [1:0]          status;
    logic                accepted;
    logic                report_now;
  } status_word_t;

  status_word_t status_q[$];

  logic [RPM_BITS-1:0] rpm_min_r, rpm_max_r;
  logic [PWM_BITS+15:0] grad_r;
  logic [PWM_BITS-1:0] duty_min_r, duty_max_r;
  logic laser_mode_r, off_at_zero_r, invert_r;

  logic [PWM_BITS-1:0] duty_s;
  logic run_s, spin_en_s, laser_en_s, dir_s;
  logic [RPM_BITS-1:0] speed_s;

  int unsigned word_idx;
  status_word_t got, want;
  logic pushed, popped;

  initial begin
    error_count = 0;
    outstanding = 0;
    word_idx = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    if (error_count < PRINT_CAP)
      $display("mismatch at status word %0d, %s: got %0h, want %0h",
               word_idx, what, got_v, want_v);
    error_count++;
  endtask

  function automatic logic [PWM_BITS-1:0] map_duty(input logic [RPM_BITS-1:0] rpm,
                                                   input logic [7:0] ovr);
    logic [63:0] scaled;
    logic [63:0] lin;
    scaled = (64'(rpm) * 64'(ovr)) / 64'(PERCENT);
    if (rpm_min_r >= rpm_max_r || scaled >= 64'(rpm_max_r)) begin
      speed_s = rpm_max_r;
      return duty_max_r;
    end
    if (scaled <= 64'(rpm_min_r)) begin
      if (scaled == 64'd0) begin
        speed_s = '0;
        return DUTY_OFF;
      end
      speed_s = rpm_min_r;
      return duty_min_r;
    end
    speed_s = scaled[RPM_BITS-1:0];
    lin = (((scaled - 64'(rpm_min_r)) * 64'(grad_r)) >> FRAC_W) + 64'(duty_min_r);
    if (lin > 64'(duty_max_r))
      lin = 64'(duty_max_r);
    return lin[PWM_BITS-1:0];
  endfunction

  function automatic status_word_t next_status(input logic [1:0] cmd,
                                               input logic [RPM_BITS-1:0] rpm,
                                               input logic [7:0] ovr,
                                               input logic ignore_w);
    status_word_t w;
    logic ccw;
    logic [RPM_BITS-1:0] rpm_eff;
    logic [PWM_BITS-1:0] duty;
    w = '0;
    if (!ignore_w) begin
      w.accepted = 1'b1;
      if (cmd == CMD_OFF) begin
        speed_s = '0;
        run_s = 1'b0;
        spin_en_s = 1'b0;
        laser_en_s = 1'b0;
      end else begin
        ccw = (cmd != CMD_CW);
        rpm_eff = rpm;
        if (laser_mode_r) begin
          if (ccw)
            rpm_eff = '0;
          laser_en_s = 1'b1;
        end else begin
          dir_s = ccw;
          spin_en_s = 1'b1;
        end
        duty = map_duty(rpm_eff, ovr);
        duty_s = duty;
        if (off_at_zero_r) begin
          if (duty == DUTY_OFF) begin
            run_s = 1'b0;
            spin_en_s = 1'b0;
            laser_en_s = 1'b0;
          end else begin
            run_s = 1'b1;
            spin_en_s = 1'b1;
          end
        end else begin
          run_s = (duty != DUTY_OFF);
        end
      end
    end
    w.pwm_duty = duty_s;
    w.pwm_running = run_s;
    w.spindle_pin = spin_en_s ^ invert_r;
    w.laser_pin = laser_en_s ^ invert_r;
    w.direction = dir_s;
    w.speed = speed_s;
    if (spin_en_s || laser_en_s)
      w.status = dir_s ? STATUS_CCW : STATUS_CW;
    else
      w.status = STATUS_OFF;
    w.report_now = w.accepted;
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rpm_min_r = '0;
      rpm_max_r = RPM_BITS'(1000);
      grad_r = (PWM_BITS+16)'(16711);
      duty_min_r = PWM_BITS'(1);
      duty_max_r = PWM_BITS'(255);
      laser_mode_r = 1'b0;
      off_at_zero_r = 1'b0;
      invert_r = 1'b0;
      duty_s = '0;
      run_s = 1'b0;
      spin_en_s = 1'b0;
      laser_en_s = 1'b0;
      dir_s = 1'b0;
      speed_s = '0;
      status_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_RPM_MIN:      rpm_min_r = cfg_wdata[RPM_BITS-1:0];
          REG_RPM_MAX:      rpm_max_r = cfg_wdata[RPM_BITS-1:0];
          REG_DUTY_SLOPE:   grad_r = cfg_wdata;
          REG_PWM_MIN_DUTY: duty_min_r = cfg_wdata[PWM_BITS-1:0];
          REG_PWM_MAX_DUTY: duty_max_r = cfg_wdata[PWM_BITS-1:0];
          REG_LASER_MODE:   laser_mode_r = cfg_wdata[0];
          REG_OFF_AT_ZERO:  off_at_zero_r = cfg_wdata[0];
          REG_INVERT_EN:    invert_r = cfg_wdata[0];
          default: ;
        endcase
      end
      pushed = in_valid && in_ready;
      popped = 1'b0;
      if (out_valid && out_ready) begin
        got.pwm_duty = out_pwm_duty;
        got.pwm_running = out_pwm_running;
        got.spindle_pin = out_spindle_enable_pin;
        got.laser_pin = out_laser_en_pin;
        got.direction = out_direction_pin;
        got.speed = out_actual_speed;
        got.status = out_spindle_status;
        got.accepted = out_accepted;
        got.report_now = out_report_now;
        if (status_q.size() == 0) begin
          report_mismatch("word with none pending", 32'd0, 32'd0);
        end else begin
          want = status_q.pop_front();
          popped = 1'b1;
          if (got.pwm_duty !== want.pwm_duty)
            report_mismatch("pwm_duty", 32'(got.pwm_duty), 32'(want.pwm_duty));
          if (got.pwm_running !== want.pwm_running)
            report_mismatch("pwm_running", 32'(got.pwm_running), 32'(want.pwm_running));
          if (got.spindle_pin !== want.spindle_pin)
            report_mismatch("spindle_enable_pin", 32'(got.spindle_pin),
                            32'(want.spindle_pin));
          if (got.laser_pin !== want.laser_pin)
            report_mismatch("laser_en_pin", 32'(got.laser_pin), 32'(want.laser_pin));
          if (got.direction !== want.direction)
            report_mismatch("direction_pin", 32'(got.direction), 32'(want.direction));
          if (got.speed !== want.speed)
            report_mismatch("actual_speed", 32'(got.speed), 32'(want.speed));
          if (got.status !== want.status)
            report_mismatch("spindle_status", 32'(got.status), 32'(want.status));
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
          if (got.report_now !== want.report_now)
            report_mismatch("report_now", 32'(got.report_now), 32'(want.report_now));
        end
        word_idx++;
      end
      if (pushed)
        status_q.push_back(next_status(in_command, in_requested_rpm, in_override_percent,
                                       in_abort_active || in_check_mode));
      outstanding <= outstanding + 32'(pushed) - 32'(popped);
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: spindle PWM controller testbench
// Drives directed and random spindle command words under several register
// settings and idle patterns, including a long output stall, while the
// status checker predicts and compares every status word.
// ----------------------------------------------------------------------------
module tb;
  import spc_pkg::*;

  localparam int PWM_BITS = 10;
  localparam int RPM_BITS = 16;
  localparam logic [1:0] CMD_CCW = 2'd2;
  localparam logic [1:0] CMD_CODE3 = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned WORDS_PER_PHASE = 120;
  localparam int unsigned NUM_PHASES = 10;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_command;
  logic [RPM_BITS-1:0]    in_requested_rpm;
  logic [7:0]             in_override_percent;
  logic                   in_abort_active;
  logic                   in_check_mode;
  logic                   out_valid;
  logic                   out_ready;
  logic [PWM_BITS-1:0]    out_pwm_duty;
  logic                   out_pwm_running;
  logic                   out_spindle_enable_pin;
  logic                   out_laser_en_pin;
  logic                   out_direction_pin;
  logic [RPM_BITS-1:0]    out_actual_speed;
  logic [1:0]             out_spindle_status;
  logic                   out_accepted;
  logic                   out_report_now;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [PWM_BITS+15:0]   cfg_wdata;
  int unsigned            error_count;
  int unsigned            outstanding;

  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 68;
  int unsigned hold_cycles = 0;
  int unsigned stall_cnt = 0;
  int unsigned cur_rpm_min = 0;
  int unsigned cur_rpm_max = 1000;

  spindle_pwm_controller #(.PWM_BITS(PWM_BITS), .RPM_BITS(RPM_BITS)) uut (.*);

  spindle_status_checker #(.PWM_BITS(PWM_BITS), .RPM_BITS(RPM_BITS)) status_chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [RPM_BITS-1:0] rpm,
                           input logic [7:0] ovr, input logic abort_f, input logic check_f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_requested_rpm <= rpm;
    in_override_percent <= ovr;
    in_abort_active <= abort_f;
    in_check_mode <= check_f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[PWM_BITS+15:0];
    @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned rmin, input int unsigned rmax,
                              input int unsigned grad, input int unsigned dmin,
                              input int unsigned dmax, input bit laser, input bit offz,
                              input bit inv);
    write_reg(REG_RPM_MIN, rmin);
    write_reg(REG_RPM_MAX, rmax);
    write_reg(REG_DUTY_SLOPE, grad);
    write_reg(REG_PWM_MIN_DUTY, dmin);
    write_reg(REG_PWM_MAX_DUTY, dmax);
    write_reg(REG_LASER_MODE, 32'(laser));
    write_reg(REG_OFF_AT_ZERO, 32'(offz));
    write_reg(REG_INVERT_EN, 32'(inv));
    cfg_we <= 1'b0;
    cur_rpm_min = rmin & 32'hFFFF;
    cur_rpm_max = rmax & 32'hFFFF;
  endtask

  task automatic random_settings();
    int unsigned rmin, rmax, dmin, dmax, grad;
    if ($urandom_range(0, 3) == 0) begin
      rmin = $urandom_range(0, 65535);
      rmax = $urandom_range(0, 65535);
      grad = $urandom & 32'h03FF_FFFF;
      dmin = $urandom_range(0, 1023);
      dmax = $urandom_range(0, 1023);
    end else begin
      rmin = $urandom_range(0, 2000);
      rmax = rmin + $urandom_range(1, 30000);
      dmin = $urandom_range(0, 64);
      dmax = $urandom_range(dmin, 1023);
      grad = ((dmax - dmin) << FRAC_W) / (rmax - rmin) + $urandom_range(0, 255);
    end
    program_regs(rmin, rmax, grad, dmin, dmax, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_random(input int unsigned n_words);
    int unsigned applied;
    int v;
    int unsigned hi;
    logic [1:0] cmd;
    logic [RPM_BITS-1:0] rpm;
    logic [7:0] ovr;
    logic abort_f, check_f;
    applied = 0;
    while (applied < n_words) begin
      if ($urandom_range(0, 15) == 0)
        ovr = 8'($urandom_range(0, 255));
      else
        ovr = 8'($urandom_range(10, 200));
      case ($urandom_range(0, 7))
        0: rpm = RPM_BITS'($urandom);
        1: rpm = '0;
        2, 3: begin
          v = ($urandom_range(0, 1) == 0) ? int'(cur_rpm_min) : int'(cur_rpm_max);
          v = v + int'($urandom_range(0, 4)) - 2;
          if (v < 0)
            v = 0;
          if (v > 65535)
            v = 65535;
          rpm = RPM_BITS'(v);
          ovr = 8'(PERCENT);
        end
        default: begin
          hi = cur_rpm_max + cur_rpm_max / 4 + 1;
          if (hi > 65535)
            hi = 65535;
          rpm = RPM_BITS'($urandom_range(0, hi));
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1:    cmd = CMD_OFF;
        2, 3, 4, 5: cmd = CMD_CW;
        9:       cmd = CMD_CODE3;
        default: cmd = CMD_CCW;
      endcase
      abort_f = ($urandom_range(0, 11) == 0);
      check_f = ($urandom_range(0, 11) == 0);
      send_word(cmd, rpm, ovr, abort_f, check_f);
      if (!abort_f && !check_f)
        applied++;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_OFF;
    in_requested_rpm <= '0;
    in_override_percent <= 8'(PERCENT);
    in_abort_active <= 1'b0;
    in_check_mode <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_RPM_MIN;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_OFF, 16'd0, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd0, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd1, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd500, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd999, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd1000, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CW, 16'hFFFF, 8'd200, 1'b0, 1'b0);
    send_word(CMD_CW, 16'hFFFF, 8'd10, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd500, 8'd0, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd300, 8'd255, 1'b0, 1'b0);
    send_word(CMD_CCW, 16'd700, 8'd150, 1'b0, 1'b0);
    send_word(CMD_CODE3, 16'd300, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd800, 8'd100, 1'b1, 1'b0);
    send_word(CMD_OFF, 16'd800, 8'd100, 1'b0, 1'b1);
    send_word(CMD_OFF, 16'd0, 8'd100, 1'b1, 1'b1);
    send_word(CMD_OFF, 16'd0, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CW, 16'd12345, 8'd37, 1'b0, 1'b0);
    wait_idle();

    program_regs(0, 65535, 32'h03FF_FFFF, 0, 1023, 1'b0, 1'b0, 1'b0);
    send_random(WORDS_PER_PHASE);
    wait_idle();

    program_regs(65535, 0, 0, 1023, 0, 1'b1, 1'b1, 1'b1);
    send_word(CMD_CW, 16'd0, 8'd100, 1'b0, 1'b0);
    send_word(CMD_CCW, 16'd5000, 8'd100, 1'b0, 1'b0);
    send_word(CMD_OFF, 16'd0, 8'd100, 1'b0, 1'b0);
    send_random(WORDS_PER_PHASE);

    for (int unsigned ph = 3; ph <= NUM_PHASES; ph++) begin
      wait_idle();
      if (ph >= 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (ph >= 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 30;
      end
      random_settings();
      if (ph == 7)
        hold_cycles = HOLD_LEN;
      send_random(WORDS_PER_PHASE);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ spindle_pwm_controller.f @@
design/spc_pkg.sv
design/spc_ctrl.sv
design/spc_dp.sv
design/spindle_pwm_controller.sv
tb/sv/spindle_status_checker.sv
tb/sv/tb.sv
